FILE: hdl/csat_pkg.sv
// Shared widths, types and register map of the cascaded sensor average tracker.
`default_nettype none

package csat_pkg;

  // Field widths of one sample.
  localparam int TIME_W = 32;
  localparam int TEMP_W = 11;
  localparam int HUM_W  = 10;

  // One ring row holds a temperature value in the low bits and humidity above it.
  localparam int RING_W = TEMP_W + HUM_W;

  // Stream word widths, padded to whole bytes.
  localparam int IN_USED  = TIME_W + TEMP_W + HUM_W;
  localparam int IN_W     = ((IN_USED + 7) / 8) * 8;
  localparam int IN_PAD   = IN_W - IN_USED;
  localparam int OUT_USED = 4 * TEMP_W + 4 * HUM_W;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_USED;

  // Register port.
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL = '0;
  localparam logic [DATA_W-1:0] INTERVAL_RESET = 32'd60000;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [HUM_W-1:0]         hum_t;

endpackage

`default_nettype wire

FILE: hdl/csat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/csat_div.sv
// Bit-serial signed-by-unsigned divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none

module csat_div #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR_W  = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [DIVIDEND_W-1:0] dividend,
  input  wire logic        [DIVISOR_W-1:0]  divisor,
  output logic                              busy,
  output logic                              done,
  output logic signed      [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [STEP_W-1:0]     step;
  logic                  neg;
  logic                  zero_div;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // A division by zero (no nonzero entries) returns zero.
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign quotient = zero_div ? '0 : (neg ? -$signed(quo) : $signed(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvs      <= divisor;
      zero_div <= (divisor == '0);
      neg      <= dividend[DIVIDEND_W-1];
      quo      <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cascaded_sensor_average_tracker.sv
// Top level: interval gate, three cascaded sample rings and the average sequencer.
// A sample that passes the interval gate with a good reading is read, written into the short
// rings and then averaged by six serial divisions of the shared divider; a wrap of the short
// or middle rings adds a read and update of the next ring up, and the emit step loads the
// result register. The input reopens only after the emit step, so a new good sample is not
// taken while one is in flight; a gated or failed sample leaves the sequencer idle.
// Reset: synchronous and active high; the rings read as zero, positions and sums clear, and
// the sample interval returns to 60000 ms.
`default_nettype none

module cascaded_sensor_average_tracker #(
  parameter int SHORT_DEPTH = 15,
  parameter int MID_DEPTH   = 4,
  parameter int LONG_DEPTH  = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Sample stream.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_ms [31:0], temperature_tenths [42:32], humidity_tenths [52:43], zero padding above.
  input  wire logic [csat_pkg::IN_W-1:0]     s_axis_tdata,
  // sample_ok [0].
  input  wire logic                          s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // temp_now [10:0], hum_now [20:11], temp_avg_short [31:21], temp_avg_mid [42:32],
  // temp_avg_long [53:43], hum_avg_short [63:54], hum_avg_mid [73:64],
  // hum_avg_long [83:74], zero padding above.
  output logic [csat_pkg::OUT_W-1:0]         m_axis_tdata,
  // Register port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [csat_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [csat_pkg::DATA_W-1:0]   pwdata,
  output logic      [csat_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int MAX_D = (SHORT_DEPTH > MID_DEPTH)
                         ? ((SHORT_DEPTH > LONG_DEPTH) ? SHORT_DEPTH : LONG_DEPTH)
                         : ((MID_DEPTH > LONG_DEPTH) ? MID_DEPTH : LONG_DEPTH);
  // A ring sum of MAX_D signed entries never leaves SUM_W bits.
  localparam int SUM_W = csat_pkg::TEMP_W + $clog2(MAX_D) + 1;
  localparam int CNT_W = $clog2(MAX_D + 1);
  localparam int SA_W  = $clog2(SHORT_DEPTH);
  localparam int MA_W  = $clog2(MID_DEPTH);
  localparam int LA_W  = $clog2(LONG_DEPTH);
  localparam int TW    = csat_pkg::TEMP_W;
  localparam int HW    = csat_pkg::HUM_W;

  localparam logic [1:0] RING_SHORT = 2'd0;
  localparam logic [1:0] RING_MID   = 2'd1;
  localparam logic [1:0] RING_LONG  = 2'd2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]                      state;
  logic [csat_pkg::DATA_W-1:0]     interval;
  logic [csat_pkg::TIME_W-1:0]     last_time;
  csat_pkg::temp_t                 temp_in;
  csat_pkg::hum_t                  hum_in;
  logic signed [SUM_W-1:0]         tsum [3];
  logic signed [SUM_W-1:0]         hsum [3];
  logic [CNT_W-1:0]                tcnt [3];
  logic [CNT_W-1:0]                hcnt [3];
  logic [2:0]                      wrapped;
  logic [2:0]                      wrap_now;
  logic [1:0]                      ring;
  logic                            hum_sel;
  csat_pkg::temp_t                 avg_t [3];
  csat_pkg::hum_t                  avg_h [3];
  logic [SA_W-1:0]                 short_pos;
  logic [MA_W-1:0]                 mid_pos;
  logic [LA_W-1:0]                 long_pos;

  logic [csat_pkg::RING_W-1:0]     rdata [3];
  logic [2:0]                      ram_we;
  logic [csat_pkg::RING_W-1:0]     ram_wdata;

  logic                            in_fire;
  logic                            elapsed;
  logic                            cfg_write;
  logic [csat_pkg::TIME_W-1:0]     now_ms;
  csat_pkg::temp_t                 new_t;
  csat_pkg::hum_t                  new_h;
  csat_pkg::temp_t                 old_t;
  csat_pkg::hum_t                  old_h;
  logic                            ring_last;
  logic signed [SUM_W-1:0]         tsum_next;
  logic signed [SUM_W-1:0]         hsum_next;
  logic [CNT_W-1:0]                tcnt_next;
  logic [CNT_W-1:0]                hcnt_next;

  logic                            div_start;
  logic                            div_busy;
  logic                            div_done;
  logic signed [SUM_W-1:0]         div_dividend;
  logic [CNT_W-1:0]                div_divisor;
  logic signed [SUM_W-1:0]         div_q;

  // ---------------------------------------------------------------------------------------
  // Register port. The register index is the byte address divided by four; writes to any
  // other index fall away and read back as zero.
  // ---------------------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[csat_pkg::ADDR_W-1:2] == csat_pkg::REG_INTERVAL) ? interval : '0;

  // ---------------------------------------------------------------------------------------
  // Interval gate. The elapsed time is taken modulo 2^32, so a wrapped clock still works.
  // ---------------------------------------------------------------------------------------
  assign now_ms        = s_axis_tdata[csat_pkg::TIME_W-1:0];
  assign elapsed       = (now_ms - last_time) >= interval;
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------------------
  // Ring update. The value entering a ring is the raw sample for the short rings and the
  // freshly divided average of the ring below for the other two. Sums and nonzero counts
  // are kept as running totals: the entry being overwritten is read first and backed out.
  // Rings fill strictly in order, so an entry that has not yet been written is exactly one
  // whose ring has never wrapped, and it reads as zero.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    unique case (ring)
      RING_SHORT: begin
        new_t     = temp_in;
        new_h     = hum_in;
        ring_last = (short_pos == SA_W'(SHORT_DEPTH - 1));
      end
      RING_MID: begin
        new_t     = avg_t[0];
        new_h     = avg_h[0];
        ring_last = (mid_pos == MA_W'(MID_DEPTH - 1));
      end
      default: begin
        new_t     = avg_t[1];
        new_h     = avg_h[1];
        ring_last = (long_pos == LA_W'(LONG_DEPTH - 1));
      end
    endcase
    if (wrapped[ring]) begin
      old_t = rdata[ring][TW-1:0];
      old_h = rdata[ring][csat_pkg::RING_W-1:TW];
    end else begin
      old_t = '0;
      old_h = '0;
    end
    tsum_next = tsum[ring] - SUM_W'(old_t) + SUM_W'(new_t);
    hsum_next = hsum[ring] - $signed({{(SUM_W-HW){1'b0}}, old_h})
                           + $signed({{(SUM_W-HW){1'b0}}, new_h});
    tcnt_next = tcnt[ring] - CNT_W'(old_t != '0) + CNT_W'(new_t != '0);
    hcnt_next = hcnt[ring] - CNT_W'(old_h != '0) + CNT_W'(new_h != '0);
  end

  assign ram_wdata = {new_h, new_t};
  always_comb begin
    ram_we       = '0;
    ram_we[ring] = (state == S_UPD);
  end

  // Each ring pair shares one row; read and write both sit at the ring's current position.
  csat_ram #(.WIDTH(csat_pkg::RING_W), .DEPTH(SHORT_DEPTH)) u_short_ram (
    .clk   (clk),
    .we    (ram_we[0]),
    .waddr (short_pos),
    .wdata (ram_wdata),
    .raddr (short_pos),
    .rdata (rdata[0])
  );

  csat_ram #(.WIDTH(csat_pkg::RING_W), .DEPTH(MID_DEPTH)) u_mid_ram (
    .clk   (clk),
    .we    (ram_we[1]),
    .waddr (mid_pos),
    .wdata (ram_wdata),
    .raddr (mid_pos),
    .rdata (rdata[1])
  );

  csat_ram #(.WIDTH(csat_pkg::RING_W), .DEPTH(LONG_DEPTH)) u_long_ram (
    .clk   (clk),
    .we    (ram_we[2]),
    .waddr (long_pos),
    .wdata (ram_wdata),
    .raddr (long_pos),
    .rdata (rdata[2])
  );

  // ---------------------------------------------------------------------------------------
  // Shared divider. Six averages per sample run through it one after another: temperature
  // then humidity for the short, middle and long rings in that order.
  // ---------------------------------------------------------------------------------------
  assign div_start    = (state == S_DIV);
  assign div_dividend = hum_sel ? hsum[ring] : tsum[ring];
  assign div_divisor  = hum_sel ? hcnt[ring] : tcnt[ring];

  csat_div #(.DIVIDEND_W(SUM_W), .DIVISOR_W(CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------------------------
  // Sequencer and control state.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      interval      <= csat_pkg::INTERVAL_RESET;
      last_time     <= '0;
      wrapped       <= '0;
      wrap_now      <= '0;
      ring          <= RING_SHORT;
      hum_sel       <= 1'b0;
      short_pos     <= '0;
      mid_pos       <= '0;
      long_pos      <= '0;
      m_axis_tvalid <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        tsum[r] <= '0;
        hsum[r] <= '0;
        tcnt[r] <= '0;
        hcnt[r] <= '0;
      end
    end else begin
      if (cfg_write && paddr[csat_pkg::ADDR_W-1:2] == csat_pkg::REG_INTERVAL) begin
        interval <= pwdata;
      end
      // The emit step refills the result register itself when it hands a word over.
      if (m_axis_tvalid && m_axis_tready && state != S_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          // A failed reading still moves the last-sample time but goes no further.
          if (in_fire && elapsed) begin
            last_time <= now_ms;
            if (s_axis_tuser) begin
              ring     <= RING_SHORT;
              hum_sel  <= 1'b0;
              wrap_now <= '0;
              state    <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          tsum[ring] <= tsum_next;
          hsum[ring] <= hsum_next;
          tcnt[ring] <= tcnt_next;
          hcnt[ring] <= hcnt_next;
          if (ring_last) begin
            wrapped[ring]  <= 1'b1;
            wrap_now[ring] <= 1'b1;
          end
          unique case (ring)
            RING_SHORT: short_pos <= ring_last ? '0 : short_pos + SA_W'(1);
            RING_MID:   mid_pos   <= ring_last ? '0 : mid_pos + MA_W'(1);
            default:    long_pos  <= ring_last ? '0 : long_pos + LA_W'(1);
          endcase
          state <= S_DIV;
        end
        S_DIV: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            if (!hum_sel) begin
              hum_sel <= 1'b1;
              state   <= S_DIV;
            end else begin
              hum_sel <= 1'b0;
              if (ring == RING_LONG) begin
                state <= S_EMIT;
              end else begin
                // A wrap of this ring pushes its averages into the next ring up first.
                ring  <= ring + 2'd1;
                state <= wrap_now[ring] ? S_RD : S_DIV;
              end
            end
          end
        end
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers carry no reset; every average is rebuilt before it is used.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire) begin
      temp_in <= s_axis_tdata[csat_pkg::TIME_W +: TW];
      hum_in  <= s_axis_tdata[csat_pkg::TIME_W + TW +: HW];
    end
    if (state == S_WAIT && div_done) begin
      if (hum_sel) begin
        avg_h[ring] <= div_q[HW-1:0];
      end else begin
        avg_t[ring] <= div_q[TW-1:0];
      end
    end
    if (state == S_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {{csat_pkg::OUT_PAD{1'b0}}, avg_h[2], avg_h[1], avg_h[0],
                       avg_t[2], avg_t[1], avg_t[0], hum_in, temp_in};
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  a_div_not_overlapped: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_EMIT)
    else $error("result word raised outside the emit step");

  a_short_count_bound: assert property (@(posedge clk) disable iff (rst)
    tcnt[0] <= CNT_W'(SHORT_DEPTH) && hcnt[0] <= CNT_W'(SHORT_DEPTH))
    else $error("short ring nonzero count exceeds depth");

  a_zero_count_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (tcnt[2] != '0 || tsum[2] == '0) && (hcnt[2] != '0 || hsum[2] == '0))
    else $error("long ring sum nonzero with no nonzero entries");

endmodule

`default_nettype wire
